// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the back end of the vertex lighting block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_ALWAYS(name, !(cond), msg)

`endif

// ===== hw/rtl/plva_pkg.sv =====
// Shared widths, register codes and beat types of the vertex lighting block.
package plva_pkg;

  localparam int IDX_W        = 12;
  localparam int VERTEX_COUNT = 4096;
  localparam int POS_W        = 24;
  localparam int NRM_W        = 16;
  localparam int RNG_W        = 23;
  localparam int COL_W        = 8;

  // Arithmetic widths.
  localparam int DIFF_W  = POS_W + 1;
  localparam int DIST2_W = 2 * RNG_W;
  localparam int ROOT_W  = RNG_W;
  localparam int LN_W    = NRM_W;
  localparam int NUM_W   = DIST2_W + 16;
  localparam int DIVD_W  = DIST2_W;
  localparam int QUO_W   = 19;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = QUO_W;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFS_X,
    REG_OFS_Y,
    REG_OFS_Z,
    REG_RANGE,
    REG_RED,
    REG_GREEN,
    REG_BLUE
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] ofs_x;
    logic signed [POS_W-1:0] ofs_y;
    logic signed [POS_W-1:0] ofs_z;
    logic [RNG_W-1:0]        range;
    logic [COL_W-1:0]        red;
    logic [COL_W-1:0]        green;
    logic [COL_W-1:0]        blue;
  } light_cfg_t;

  // Classified vertex handed from the front to the back.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             lit;
    logic [COL_W-1:0] add_r;
    logic [COL_W-1:0] add_g;
    logic [COL_W-1:0] add_b;
  } lit_item_t;

  // Result beat.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             lit;
  } color_item_t;

endpackage

// ===== hw/rtl/plva_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module plva_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [plva_pkg::DIST2_W-1:0]  rad_i,
  output logic [plva_pkg::ROOT_W-1:0]   root_o
);
  import plva_pkg::*;

  localparam int RW = DIST2_W + 1;

  logic [DIST2_W-1:0] rem_q  [SQRT_LAT];
  logic [RW-1:0]      res_q  [SQRT_LAT];
  logic [DIST2_W-1:0] rem_in [SQRT_LAT];
  logic [RW-1:0]      res_in [SQRT_LAT];
  logic [RW-1:0]      pw_w   [SQRT_LAT];
  logic [RW-1:0]      trial_w[SQRT_LAT];
  logic [DIST2_W-1:0] rem_d  [SQRT_LAT];
  logic [RW-1:0]      res_d  [SQRT_LAT];

  always_comb begin
    for (int k = 0; k < SQRT_LAT; k++) begin
      if (k == 0) begin
        rem_in[k] = rad_i;
        res_in[k] = '0;
      end else begin
        rem_in[k] = rem_q[k-1];
        res_in[k] = res_q[k-1];
      end
      pw_w[k]    = RW'(1) << (2 * (SQRT_LAT - 1 - k));
      trial_w[k] = res_in[k] + pw_w[k];
      if (RW'(rem_in[k]) >= trial_w[k]) begin
        rem_d[k] = rem_in[k] - trial_w[k][DIST2_W-1:0];
        res_d[k] = (res_in[k] >> 1) + pw_w[k];
      end else begin
        rem_d[k] = rem_in[k];
        res_d[k] = res_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
      end
    end
  end

  assign root_o = res_q[SQRT_LAT-1][ROOT_W-1:0];

endmodule

// ===== hw/rtl/plva_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module plva_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [plva_pkg::NUM_W-1:0]   num_i,
  input  logic [plva_pkg::DIVD_W-1:0]  den_i,
  output logic [plva_pkg::QUO_W-1:0]   quo_o
);
  import plva_pkg::*;

  localparam int CW = NUM_W + QUO_W;

  logic [NUM_W-1:0]  rem_q [DIV_LAT];
  logic [DIVD_W-1:0] den_q [DIV_LAT];
  logic [QUO_W-1:0]  quo_q [DIV_LAT];
  logic [NUM_W-1:0]  rem_in[DIV_LAT];
  logic [DIVD_W-1:0] den_in[DIV_LAT];
  logic [QUO_W-1:0]  quo_in[DIV_LAT];
  logic [CW-1:0]     sh_w  [DIV_LAT];
  logic [NUM_W-1:0]  rem_d [DIV_LAT];
  logic [QUO_W-1:0]  quo_d [DIV_LAT];

  always_comb begin
    for (int k = 0; k < DIV_LAT; k++) begin
      if (k == 0) begin
        rem_in[k] = num_i;
        den_in[k] = den_i;
        quo_in[k] = '0;
      end else begin
        rem_in[k] = rem_q[k-1];
        den_in[k] = den_q[k-1];
        quo_in[k] = quo_q[k-1];
      end
      sh_w[k] = CW'(den_in[k]) << (QUO_W - 1 - k);
      if (CW'(rem_in[k]) >= sh_w[k]) begin
        rem_d[k] = rem_in[k] - sh_w[k][NUM_W-1:0];
        quo_d[k] = quo_in[k] | (QUO_W'(1) << (QUO_W - 1 - k));
      end else begin
        rem_d[k] = rem_in[k];
        quo_d[k] = quo_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_in[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule

// ===== hw/rtl/plva_front.sv =====
// Front pipeline: distance, facing test, square roots, divisions and channel gains.
module plva_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              acc_i,
  input  plva_pkg::light_cfg_t              cfg_i,
  input  logic [plva_pkg::IDX_W-1:0]        vertex_index_i,
  input  logic signed [plva_pkg::POS_W-1:0] vertex_x_i,
  input  logic signed [plva_pkg::POS_W-1:0] vertex_y_i,
  input  logic signed [plva_pkg::POS_W-1:0] vertex_z_i,
  input  logic signed [plva_pkg::NRM_W-1:0] normal_x_i,
  input  logic signed [plva_pkg::NRM_W-1:0] normal_y_i,
  input  logic signed [plva_pkg::NRM_W-1:0] normal_z_i,
  output logic                              push_o,
  output plva_pkg::lit_item_t               item_o
);
  import plva_pkg::*;

  localparam int SQ_W    = 2 * POS_W;
  localparam int SUM2_W  = SQ_W + 2;
  localparam int PROD_W  = NRM_W + DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int DOTP_W  = PROD_W;
  localparam int NSQ_W   = 2 * NRM_W - 1;
  localparam int NN_W    = 2 * NRM_W;
  localparam int DEN_W   = LN_W + ROOT_W;
  localparam int FRAC_W  = 16;
  localparam int KQ_W    = 16;
  localparam int COS_W   = 17;
  localparam int COS_ONE = 65536;
  localparam int KC_W    = KQ_W + COS_W;
  localparam int ADD_LSB = 32;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               lit;
    logic [DOTP_W-1:0]  dot;
    logic [DIST2_W-1:0] dst2;
  } side_a_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             lit;
  } side_b_t;

  // Stage 1: vector to the light.
  logic                     v1_q;
  logic [IDX_W-1:0]         idx1_q;
  logic signed [DIFF_W-1:0] dx1_q, dy1_q, dz1_q;
  logic signed [NRM_W-1:0]  nx1_q, ny1_q, nz1_q;

  // Stage 2: products.
  logic                        v2_q;
  logic [IDX_W-1:0]            idx2_q;
  logic [SQ_W-1:0]             sqx2_q, sqy2_q, sqz2_q;
  logic signed [PROD_W-1:0]    pdx2_q, pdy2_q, pdz2_q;
  logic [NSQ_W-1:0]            nnx2_q, nny2_q, nnz2_q;
  logic signed [2*DIFF_W-1:0]  sqx_w, sqy_w, sqz_w;
  logic signed [PROD_W-1:0]    pdx_w, pdy_w, pdz_w;
  logic signed [2*NRM_W-1:0]   nnx_w, nny_w, nnz_w;

  // Stage 3: sums and the lit test.
  logic                    v3_q;
  logic [IDX_W-1:0]        idx3_q;
  logic [SUM2_W-1:0]       dst2_q;
  logic signed [DOT_W-1:0] dot3_q;
  logic [NN_W-1:0]         nn3_q;
  logic [DIVD_W-1:0]       range2_q;
  logic                    lit3_w;

  // Square root line.
  logic [ROOT_W-1:0] root_d_w, root_n_w;
  logic              va_q    [SQRT_LAT];
  side_a_t           side_a_q[SQRT_LAT];

  // Divisor stage.
  logic             vd_q;
  side_a_t          sd_q;
  logic [DEN_W-1:0] den_q;

  // Division line.
  logic [QUO_W-1:0] quo_cos_w, quo_kq_w;
  logic             vb_q    [DIV_LAT];
  side_b_t          side_b_q[DIV_LAT];

  // Gain stages.
  logic               vc_q;
  side_b_t            sc_q;
  logic [COS_W-1:0]   cos_cl_w;
  logic [KC_W-1:0]    kc_w, kc_q;
  logic [KC_W+COL_W-1:0] pr_r_w, pr_g_w, pr_b_w;
  logic               vm_q;
  lit_item_t          item_q;

  assign sqx_w = dx1_q * dx1_q;
  assign sqy_w = dy1_q * dy1_q;
  assign sqz_w = dz1_q * dz1_q;
  assign pdx_w = nx1_q * dx1_q;
  assign pdy_w = ny1_q * dy1_q;
  assign pdz_w = nz1_q * dz1_q;
  assign nnx_w = nx1_q * nx1_q;
  assign nny_w = ny1_q * ny1_q;
  assign nnz_w = nz1_q * nz1_q;

  assign lit3_w = (dst2_q < SUM2_W'(range2_q)) && !dot3_q[DOT_W-1] && (dot3_q != '0);

  plva_isqrt u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (dst2_q[DIST2_W-1:0]),
    .root_o (root_d_w)
  );

  plva_isqrt u_sqrt_norm (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (DIST2_W'(nn3_q)),
    .root_o (root_n_w)
  );

  plva_div u_div_cos (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (NUM_W'({sd_q.dot, FRAC_W'(0)})),
    .den_i (DIVD_W'(den_q)),
    .quo_o (quo_cos_w)
  );

  plva_div u_div_fall (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i ({range2_q - sd_q.dst2, FRAC_W'(0)}),
    .den_i (range2_q),
    .quo_o (quo_kq_w)
  );

  assign cos_cl_w = (quo_cos_w > QUO_W'(COS_ONE)) ? COS_W'(COS_ONE) : quo_cos_w[COS_W-1:0];
  assign kc_w     = quo_kq_w[KQ_W-1:0] * cos_cl_w;
  assign pr_r_w   = kc_q * cfg_i.red;
  assign pr_g_w   = kc_q * cfg_i.green;
  assign pr_b_w   = kc_q * cfg_i.blue;

  // Valid line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vd_q <= 1'b0;
      vc_q <= 1'b0;
      vm_q <= 1'b0;
      for (int k = 0; k < SQRT_LAT; k++) va_q[k] <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) vb_q[k] <= 1'b0;
    end else if (en_i) begin
      v1_q <= acc_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      va_q[0] <= v3_q;
      for (int k = 1; k < SQRT_LAT; k++) va_q[k] <= va_q[k-1];
      vd_q <= va_q[SQRT_LAT-1];
      vb_q[0] <= vd_q;
      for (int k = 1; k < DIV_LAT; k++) vb_q[k] <= vb_q[k-1];
      vc_q <= vb_q[DIV_LAT-1];
      vm_q <= vc_q;
    end
  end

  // The squared range follows the register; the user, not the block, keeps it stable while items are in flight.
  always_ff @(posedge clk_i) begin
    range2_q <= cfg_i.range * cfg_i.range;
  end

  // Payload line.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx1_q <= vertex_index_i;
      dx1_q  <= DIFF_W'(cfg_i.ofs_x) - DIFF_W'(vertex_x_i);
      dy1_q  <= DIFF_W'(cfg_i.ofs_y) - DIFF_W'(vertex_y_i);
      dz1_q  <= DIFF_W'(cfg_i.ofs_z) - DIFF_W'(vertex_z_i);
      nx1_q  <= normal_x_i;
      ny1_q  <= normal_y_i;
      nz1_q  <= normal_z_i;

      idx2_q <= idx1_q;
      sqx2_q <= sqx_w[SQ_W-1:0];
      sqy2_q <= sqy_w[SQ_W-1:0];
      sqz2_q <= sqz_w[SQ_W-1:0];
      pdx2_q <= pdx_w;
      pdy2_q <= pdy_w;
      pdz2_q <= pdz_w;
      nnx2_q <= nnx_w[NSQ_W-1:0];
      nny2_q <= nny_w[NSQ_W-1:0];
      nnz2_q <= nnz_w[NSQ_W-1:0];

      idx3_q <= idx2_q;
      dst2_q <= SUM2_W'(sqx2_q) + SUM2_W'(sqy2_q) + SUM2_W'(sqz2_q);
      dot3_q <= DOT_W'(pdx2_q) + DOT_W'(pdy2_q) + DOT_W'(pdz2_q);
      nn3_q  <= NN_W'(nnx2_q) + NN_W'(nny2_q) + NN_W'(nnz2_q);

      side_a_q[0].idx  <= idx3_q;
      side_a_q[0].lit  <= lit3_w;
      side_a_q[0].dot  <= dot3_q[DOTP_W-1:0];
      side_a_q[0].dst2 <= dst2_q[DIST2_W-1:0];
      for (int k = 1; k < SQRT_LAT; k++) side_a_q[k] <= side_a_q[k-1];

      sd_q  <= side_a_q[SQRT_LAT-1];
      den_q <= root_n_w[LN_W-1:0] * root_d_w;

      side_b_q[0].idx <= sd_q.idx;
      side_b_q[0].lit <= sd_q.lit;
      for (int k = 1; k < DIV_LAT; k++) side_b_q[k] <= side_b_q[k-1];

      sc_q <= side_b_q[DIV_LAT-1];
      kc_q <= kc_w;

      item_q.idx   <= sc_q.idx;
      item_q.lit   <= sc_q.lit;
      item_q.add_r <= pr_r_w[ADD_LSB +: COL_W];
      item_q.add_g <= pr_g_w[ADD_LSB +: COL_W];
      item_q.add_b <= pr_b_w[ADD_LSB +: COL_W];
    end
  end

  assign push_o = en_i && vm_q;
  assign item_o = item_q;

endmodule

// ===== hw/rtl/plva_queue.sv =====
// Short queue of classified vertices between the front and the back.
module plva_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  plva_pkg::lit_item_t  item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output plva_pkg::lit_item_t  item_o
);
  import plva_pkg::*;

  lit_item_t         slot_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= item_i;
  end

endmodule

// ===== hw/rtl/plva_back.sv =====
// Back end: colour store read-modify-write, clearing pass and result buffer.
`include "assert_macros.svh"

module plva_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  plva_pkg::lit_item_t   q_item_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output plva_pkg::color_item_t out_item_o
);
  import plva_pkg::*;

  localparam int ODEPTH = 4;
  localparam int OPTR_W = 2;
  localparam int OCNT_W = 3;
  localparam int ENT_W  = 3 * COL_W;

  logic [ENT_W-1:0] store_q [VERTEX_COUNT];
  logic [ENT_W-1:0] rd_q;

  logic             clr_q;
  logic [IDX_W-1:0] clr_cnt_q;

  logic             s1_v_q;
  lit_item_t        s1_q;

  logic             byp_v_q;
  logic [IDX_W-1:0] byp_idx_q;
  logic [ENT_W-1:0] byp_data_q;

  color_item_t       obuf_q [ODEPTH];
  logic [OPTR_W-1:0] owp_q, orp_q;
  logic [OCNT_W-1:0] ocnt_q;

  logic             pop_w, wr_w, opop_w;
  logic [ENT_W-1:0] cur_w, new_w;
  logic [COL_W:0]   sum_r_w, sum_g_w, sum_b_w;
  logic [COL_W-1:0] sat_r_w, sat_g_w, sat_b_w;
  color_item_t      res_w;

  // A slot in the result buffer is reserved for the beat that is in the update stage.
  assign pop_w = !q_empty_i && !clr_q && ((ocnt_q + OCNT_W'(s1_v_q)) < OCNT_W'(ODEPTH));

  // The previous update wrote the store at the edge this entry was read.
  assign cur_w = (byp_v_q && (byp_idx_q == s1_q.idx)) ? byp_data_q : rd_q;

  assign sum_r_w = {1'b0, cur_w[3*COL_W-1:2*COL_W]} + {1'b0, s1_q.add_r};
  assign sum_g_w = {1'b0, cur_w[2*COL_W-1:COL_W]} + {1'b0, s1_q.add_g};
  assign sum_b_w = {1'b0, cur_w[COL_W-1:0]} + {1'b0, s1_q.add_b};
  assign sat_r_w = sum_r_w[COL_W] ? '1 : sum_r_w[COL_W-1:0];
  assign sat_g_w = sum_g_w[COL_W] ? '1 : sum_g_w[COL_W-1:0];
  assign sat_b_w = sum_b_w[COL_W] ? '1 : sum_b_w[COL_W-1:0];
  assign new_w   = s1_q.lit ? {sat_r_w, sat_g_w, sat_b_w} : cur_w;
  assign wr_w    = s1_v_q && s1_q.lit;

  assign res_w.idx   = s1_q.idx;
  assign res_w.red   = new_w[3*COL_W-1:2*COL_W];
  assign res_w.green = new_w[2*COL_W-1:COL_W];
  assign res_w.blue  = new_w[COL_W-1:0];
  assign res_w.lit   = s1_q.lit;

  assign opop_w      = (ocnt_q != '0) && !out_stall_i;
  assign out_valid_o = (ocnt_q != '0);
  assign out_item_o  = obuf_q[orp_q];
  assign pop_o       = pop_w;
  assign clearing_o  = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      byp_v_q   <= 1'b0;
      owp_q     <= '0;
      orp_q     <= '0;
      ocnt_q    <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(VERTEX_COUNT - 1)) clr_q <= 1'b0;
      end
      s1_v_q  <= pop_w;
      byp_v_q <= wr_w;
      if (s1_v_q) owp_q <= owp_q + 1'b1;
      if (opop_w) orp_q <= orp_q + 1'b1;
      if (s1_v_q && !opop_w) begin
        ocnt_q <= ocnt_q + 1'b1;
      end else if (opop_w && !s1_v_q) begin
        ocnt_q <= ocnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      store_q[clr_cnt_q] <= '0;
    end else if (wr_w) begin
      store_q[s1_q.idx] <= new_w;
    end
    if (pop_w) rd_q <= store_q[q_item_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (pop_w) s1_q <= q_item_i;
    byp_idx_q  <= s1_q.idx;
    byp_data_q <= new_w;
    if (s1_v_q) obuf_q[owp_q] <= res_w;
  end

  `ASSERT_NEVER(a_item_in_clear, clr_q && s1_v_q, "vertex updated during clearing pass")
  `ASSERT_NEVER(a_obuf_overflow, s1_v_q && !opop_w && (ocnt_q == OCNT_W'(ODEPTH)), "result buffer overflow")
  `ASSERT_ALWAYS(a_clear_length, $fell(clr_q) |-> ($past(clr_cnt_q) == IDX_W'(VERTEX_COUNT - 1)), "clearing pass ended early")

endmodule

// ===== hw/rtl/point_light_vertex_accumulate_core.sv =====
// Top level of the point-light per-vertex colour accumulator.
//
//   channel   direction  handshake            beat
//   cfg       in         cfg_valid/cfg_ready  register index and write data
//   in        in         in_valid/in_stall    vertex index, position, normal
//   out       out        out_valid/out_stall  vertex index, new RGB, lit flag
//
// One vertex beat is accepted per cycle while in_stall is low; a result beat passes the
// 23-stage square roots and the 19-stage dividers of the front pipeline and then the
// store update in the back. After reset a clearing pass writes zero into all 4096 store
// entries, one per cycle; in_stall stays high during the pass, while configuration
// writes are taken. A stall on the result side fills the result buffer and then the
// queue, after which the front pipeline freezes and in_stall rises.
module point_light_vertex_accumulate_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration writes.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [plva_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [plva_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // Vertex beats.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [plva_pkg::IDX_W-1:0]             vertex_index_i,
  input  logic signed [plva_pkg::POS_W-1:0]      vertex_x_i,
  input  logic signed [plva_pkg::POS_W-1:0]      vertex_y_i,
  input  logic signed [plva_pkg::POS_W-1:0]      vertex_z_i,
  input  logic signed [plva_pkg::NRM_W-1:0]      normal_x_i,
  input  logic signed [plva_pkg::NRM_W-1:0]      normal_y_i,
  input  logic signed [plva_pkg::NRM_W-1:0]      normal_z_i,
  // Result beats.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [plva_pkg::IDX_W-1:0]             out_index_o,
  output logic [plva_pkg::COL_W-1:0]             out_red_o,
  output logic [plva_pkg::COL_W-1:0]             out_green_o,
  output logic [plva_pkg::COL_W-1:0]             out_blue_o,
  output logic                                   was_lit_o
);
  import plva_pkg::*;

  light_cfg_t  cfg_q;
  logic        q_full_w, q_empty_w, q_push_w, q_pop_w;
  logic        clearing_w, en_w, acc_w;
  lit_item_t   q_in_w, q_out_w;
  color_item_t res_w;

  // Register file. Writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ofs_x <= '0;
      cfg_q.ofs_y <= '0;
      cfg_q.ofs_z <= '0;
      cfg_q.range <= '0;
      cfg_q.red   <= '1;
      cfg_q.green <= '1;
      cfg_q.blue  <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OFS_X: cfg_q.ofs_x <= cfg_data_i[POS_W-1:0];
        REG_OFS_Y: cfg_q.ofs_y <= cfg_data_i[POS_W-1:0];
        REG_OFS_Z: cfg_q.ofs_z <= cfg_data_i[POS_W-1:0];
        REG_RANGE: cfg_q.range <= cfg_data_i[RNG_W-1:0];
        REG_RED:   cfg_q.red   <= cfg_data_i[COL_W-1:0];
        REG_GREEN: cfg_q.green <= cfg_data_i[COL_W-1:0];
        REG_BLUE:  cfg_q.blue  <= cfg_data_i[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole front pipeline moves together while the queue has a free slot.
  assign en_w       = !q_full_w;
  assign in_stall_o = q_full_w || clearing_w;
  assign acc_w      = in_valid_i && !in_stall_o;

  plva_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en_w),
    .acc_i          (acc_w),
    .cfg_i          (cfg_q),
    .vertex_index_i (vertex_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .vertex_z_i     (vertex_z_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .push_o         (q_push_w),
    .item_o         (q_in_w)
  );

  plva_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push_w),
    .item_i  (q_in_w),
    .full_o  (q_full_w),
    .pop_i   (q_pop_w),
    .empty_o (q_empty_w),
    .item_o  (q_out_w)
  );

  plva_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty_w),
    .q_item_i    (q_out_w),
    .pop_o       (q_pop_w),
    .clearing_o  (clearing_w),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (res_w)
  );

  assign out_index_o = res_w.idx;
  assign out_red_o   = res_w.red;
  assign out_green_o = res_w.green;
  assign out_blue_o  = res_w.blue;
  assign was_lit_o   = res_w.lit;

endmodule

// ===== test/tb_point_light_vertex_accumulate_core.sv =====
// Self-checking testbench of the point-light per-vertex colour accumulator.
module tb_point_light_vertex_accumulate_core;
  import plva_pkg::*;

  // The longest correct run is dominated by the clearing pass and
  // by stall bursts on the result side. The limit leaves wide margin on top.
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int POS_MAX = 8388607;
  localparam int POS_MIN = -8388608;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [IDX_W-1:0]       vertex_index_i = '0;
  logic signed [POS_W-1:0] vertex_x_i = '0;
  logic signed [POS_W-1:0] vertex_y_i = '0;
  logic signed [POS_W-1:0] vertex_z_i = '0;
  logic signed [NRM_W-1:0] normal_x_i = '0;
  logic signed [NRM_W-1:0] normal_y_i = '0;
  logic signed [NRM_W-1:0] normal_z_i = '0;

  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [IDX_W-1:0]       out_index_o;
  logic [COL_W-1:0]       out_red_o;
  logic [COL_W-1:0]       out_green_o;
  logic [COL_W-1:0]       out_blue_o;
  logic                   was_lit_o;

  point_light_vertex_accumulate_core i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .vertex_index_i,
    .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .normal_x_i, .normal_y_i, .normal_z_i,
    .out_valid_o, .out_stall_i, .out_index_o,
    .out_red_o, .out_green_o, .out_blue_o, .was_lit_o
  );

  // Our own copy of the light registers and of the colour store.
  longint light_x, light_y, light_z;
  longint unsigned light_reach;
  longint unsigned light_col [3];
  logic [3*COL_W-1:0] colour_mem [VERTEX_COUNT];

  color_item_t pending_colours[$];
  int  error_count = 0;
  int  cycle_count = 0;
  // When set, neither side inserts idle cycles any more.
  bit  quiet_tail = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake must not hang the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_light_vertex_accumulate_core: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("error at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Lights one vertex against the current light and updates the colour copy.
  function automatic color_item_t shade_vertex(input logic [IDX_W-1:0] idx,
      input longint vx, input longint vy, input longint vz,
      input longint nx, input longint ny, input longint nz);
    color_item_t res;
    longint dx, dy, dz, dot;
    longint unsigned dist2, range2, ln, ld, den, cosq, kq, sum;
    logic [COL_W-1:0] chan [3];
    dx = light_x - vx;
    dy = light_y - vy;
    dz = light_z - vz;
    chan[0] = colour_mem[idx][23:16];
    chan[1] = colour_mem[idx][15:8];
    chan[2] = colour_mem[idx][7:0];
    dist2 = dx * dx + dy * dy + dz * dz;
    range2 = light_reach * light_reach;
    dot = nx * dx + ny * dy + nz * dz;
    res.lit = 1'b0;
    if (dist2 < range2 && dot > 0) begin
      ln = int_sqrt(nx * nx + ny * ny + nz * nz);
      ld = int_sqrt(dist2);
      den = ln * ld;
      cosq = 0;
      kq = ((range2 - dist2) << 16) / range2;
      if (den != 0) begin
        cosq = (longint'(dot) << 16) / den;
        if (cosq > 65536) cosq = 65536;
      end
      for (int c = 0; c < 3; c++) begin
        sum = chan[c] + ((kq * light_col[c] * cosq) >> 32);
        chan[c] = (sum > 255) ? 8'd255 : sum[7:0];
      end
      colour_mem[idx] = {chan[0], chan[1], chan[2]};
      res.lit = 1'b1;
    end
    res.idx = idx;
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    return res;
  endfunction

  // Result side: each accepted beat is held against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colours.size() == 0) begin
        report_mismatch("unexpected result beat, index", out_index_o, -1);
      end else begin
        color_item_t want;
        want = pending_colours.pop_front();
        if (out_index_o !== want.idx) report_mismatch("out_index", out_index_o, want.idx);
        if (out_red_o !== want.red) report_mismatch("out_red", out_red_o, want.red);
        if (out_green_o !== want.green) report_mismatch("out_green", out_green_o, want.green);
        if (out_blue_o !== want.blue) report_mismatch("out_blue", out_blue_o, want.blue);
        if (was_lit_o !== want.lit) report_mismatch("was_lit", was_lit_o, want.lit);
      end
    end
  end

  // Result-side stall bursts, dropped once the quiet tail begins.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  end

  // Writes one register and mirrors it into the predictor on acceptance.
  task automatic write_light_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OFS_X: light_x = longint'(signed'(data));
      REG_OFS_Y: light_y = longint'(signed'(data));
      REG_OFS_Z: light_z = longint'(signed'(data));
      REG_RANGE: light_reach = data[22:0];
      REG_RED:   light_col[0] = data[7:0];
      REG_GREEN: light_col[1] = data[7:0];
      REG_BLUE:  light_col[2] = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_light(input int ox, input int oy, input int oz, input int reach,
      input int red, input int green, input int blue);
    write_light_reg(REG_OFS_X, ox[23:0]);
    write_light_reg(REG_OFS_Y, oy[23:0]);
    write_light_reg(REG_OFS_Z, oz[23:0]);
    write_light_reg(REG_RANGE, reach[23:0]);
    write_light_reg(REG_RED, red[23:0]);
    write_light_reg(REG_GREEN, green[23:0]);
    write_light_reg(REG_BLUE, blue[23:0]);
  endtask

  // Registers change only when the pipeline has drained completely.
  task automatic wait_drained();
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sends one vertex beat; the expectation is formed at the accepting edge.
  task automatic send_vertex(input int idx, input int vx, input int vy, input int vz,
      input int nx, input int ny, input int nz);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    vertex_index_i = idx[IDX_W-1:0];
    vertex_x_i = vx[23:0];
    vertex_y_i = vy[23:0];
    vertex_z_i = vz[23:0];
    normal_x_i = nx[15:0];
    normal_y_i = ny[15:0];
    normal_z_i = nz[15:0];
    do @(posedge clk_i); while (in_stall_o);
    pending_colours.push_back(shade_vertex(vertex_index_i, vertex_x_i, vertex_y_i,
        vertex_z_i, normal_x_i, normal_y_i, normal_z_i));
    // A gap drops valid for a burst; otherwise the next beat follows at once.
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
    end
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // With the reset light the range is zero, so nothing may be lit.
  task automatic test_reset_light();
    send_vertex(0, 0, 0, 0, 16384, 0, 0);
    send_vertex(4095, -256, 0, 0, 16384, 0, 0);
    send_vertex(7, POS_MAX, POS_MIN, 1, 32767, -32768, 1);
    end_burst();
  endtask

  // Hand-picked corners: field extremes, vertex at the light, zero normal,
  // facing away, exactly at the range, and accumulation up to saturation.
  task automatic test_directed_corners();
    wait_drained();
    load_light(0, 0, 0, 8388607, 255, 255, 255);
    send_vertex(5, 0, 0, 0, 16384, 0, 0);
    send_vertex(5, -2560, 0, 0, 0, 0, 0);
    send_vertex(5, -2560, 0, 0, -16384, 0, 0);
    for (int i = 0; i < 6; i++) send_vertex(5, -2560, 0, 0, 16384, 0, 0);
    send_vertex(4095, POS_MAX, POS_MAX, POS_MAX, -32768, -32768, -32768);
    send_vertex(0, POS_MIN, POS_MIN, POS_MIN, 32767, 32767, 32767);
    send_vertex(1, -8388607, 0, 0, 32767, 0, 0);
    end_burst();
    wait_drained();
    load_light(POS_MAX, POS_MIN, POS_MAX, 512, 0, 128, 255);
    send_vertex(9, POS_MAX - 512, POS_MIN, POS_MAX, 16384, 0, 0);
    send_vertex(9, POS_MAX - 100, POS_MIN + 50, POS_MAX, 20000, -9000, 3);
    send_vertex(9, POS_MAX - 100, POS_MIN + 50, POS_MAX, 1, 0, 0);
    send_vertex(10, POS_MIN, POS_MAX, POS_MIN, 32767, -32768, 32767);
    end_burst();
    wait_drained();
    write_light_reg(REG_UNUSED, 24'hFFFFFF);
    load_light(POS_MIN, POS_MAX, POS_MIN, 0, 255, 255, 255);
    send_vertex(9, POS_MIN + 10, POS_MAX, POS_MIN, -16384, 0, 0);
    end_burst();
  endtask

  // One light per phase; most vertices sit inside its reach and face it.
  task automatic test_random_lighting(input int items);
    int ox, oy, oz, reach, half;
    int dx, dy, dz, nx, ny, nz, idx;
    longint dot;
    wait_drained();
    ox = $urandom_range(0, 1 << 23) - (1 << 22);
    oy = $urandom_range(0, 1 << 23) - (1 << 22);
    oz = $urandom_range(0, 1 << 23) - (1 << 22);
    reach = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 4096)
                                        : $urandom_range(16, 1 << 21);
    load_light(ox, oy, oz, reach, $urandom_range(0, 255), $urandom_range(0, 255),
        ($urandom_range(0, 1) != 0) ? 255 : $urandom_range(0, 255));
    half = reach / 2;
    for (int n = 0; n < items; n++) begin
      idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 4095);
      if ($urandom_range(0, 4) == 0) begin
        send_vertex(idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        dx = $urandom_range(0, 2 * half) - half;
        dy = $urandom_range(0, 2 * half) - half;
        dz = $urandom_range(0, 2 * half) - half;
        nx = $signed(16'($urandom));
        ny = $signed(16'($urandom));
        nz = $signed(16'($urandom));
        dot = longint'(nx) * dx + longint'(ny) * dy + longint'(nz) * dz;
        // Turn the normal toward the light for most well-formed vertices.
        if (dot < 0 && $urandom_range(0, 9) != 0) begin
          nx = (nx == -32768) ? 32767 : -nx;
          ny = (ny == -32768) ? 32767 : -ny;
          nz = (nz == -32768) ? 32767 : -nz;
        end
        send_vertex(idx, ox - dx, oy - dy, oz - dz, nx, ny, nz);
      end
    end
    end_burst();
  endtask

  initial begin
    light_x = 0;
    light_y = 0;
    light_z = 0;
    light_reach = 0;
    for (int c = 0; c < 3; c++) light_col[c] = 255;
    for (int i = 0; i < VERTEX_COUNT; i++) colour_mem[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_light();
    test_directed_corners();
    for (int p = 0; p < 7; p++) test_random_lighting(150);
    quiet_tail = 1'b1;
    test_random_lighting(150);

    wait_drained();
    if (error_count == 0) begin
      $display("point_light_vertex_accumulate_core: match");
    end else begin
      $display("point_light_vertex_accumulate_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/plva_pkg.sv
hw/rtl/plva_isqrt.sv
hw/rtl/plva_div.sv
hw/rtl/plva_front.sv
hw/rtl/plva_queue.sv
hw/rtl/plva_back.sv
hw/rtl/point_light_vertex_accumulate_core.sv
test/tb_point_light_vertex_accumulate_core.sv
